// ===== src/kdds_pkg.sv =====
// ----------------------------------------------------------------------------
// kdds_pkg
// Shared types, constants and the digit glyph table for the keypad
// decimal entry and duty set block.
// ----------------------------------------------------------------------------
`default_nettype none

package kdds_pkg;

	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned NUM_DIG  = 4;
	localparam int unsigned POS_W    = 3;
	localparam int unsigned DUTY_W   = 14;
	localparam int unsigned SEG_W    = 8;
	localparam int unsigned PHASE_W  = 2;
	localparam int unsigned APB_AW   = 1;
	localparam int unsigned APB_DW   = 32;

	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 14'd1000;
	localparam logic [APB_AW-1:0] ADDR_DUTY_LIMIT = 1'b0;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [DIGIT_W-1:0] KEY_STAR_VAL = 4'd0;

	typedef logic [DIGIT_W-1:0] digit_t;

	// Decoded keypad columns, column 1 on its own (star release sits between
	// column 1 and the rest), columns 2/3 merged with column 3 winning.
	typedef struct packed {
		logic   c1_hit;
		digit_t c1_key;
		logic   star;
		logic   c23_hit;
		digit_t c23_key;
		logic   hash;
	} kdds_keys_t;

	function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hdb;
			4'd1: s = 8'h50;
			4'd2: s = 8'h1f;
			4'd3: s = 8'h5d;
			4'd4: s = 8'hd4;
			4'd5: s = 8'hcd;
			4'd6: s = 8'hcf;
			4'd7: s = 8'hd8;
			4'd8: s = 8'hdf;
			4'd9: s = 8'hdd;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== src/kdds_in_if.sv =====
// ----------------------------------------------------------------------------
// kdds_in_if
// Input channel: scan or tick beat with three active-low column row sets.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdds_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [3:0] col1_rows;
	logic [3:0] col2_rows;
	logic [3:0] col3_rows;

	modport source (output valid, operation, col1_rows, col2_rows, col3_rows,
		input ready);
	modport sink (input valid, operation, col1_rows, col2_rows, col3_rows,
		output ready);
endinterface

`default_nettype wire

// ===== src/kdds_out_if.sv =====
// ----------------------------------------------------------------------------
// kdds_out_if
// Result channel: duty value and the current display drive.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdds_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] duty;
	logic [7:0]  segments;
	logic [3:0]  digit_enable;

	modport source (output valid, duty, segments, digit_enable, input ready);
	modport sink (input valid, duty, segments, digit_enable, output ready);
endinterface

`default_nettype wire

// ===== src/kdds_key_decode.sv =====
// ----------------------------------------------------------------------------
// kdds_key_decode
// Priority decode of the 3x4 keypad matrix, active-low rows.
// ----------------------------------------------------------------------------
`default_nettype none

module kdds_key_decode
	import kdds_pkg::*;
(
	input  wire logic [3:0] col1_rows,
	input  wire logic [3:0] col2_rows,
	input  wire logic [3:0] col3_rows,
	output kdds_keys_t      keys
);

	logic   c1_hit, c2_hit, c3_hit;
	logic   star, hash;
	digit_t c1_key, c2_key, c3_key;
	logic   c23_hit;
	digit_t c23_key;

	always_comb begin
		c1_hit = 1'b1;
		star   = 1'b0;
		// row priority: top row, then bits 3, 2, then the bottom row
		if (!col1_rows[0]) begin
			c1_key = 4'd1;
		end else if (!col1_rows[3]) begin
			c1_key = 4'd4;
		end else if (!col1_rows[2]) begin
			c1_key = 4'd7;
		end else if (!col1_rows[1]) begin
			c1_key = KEY_STAR_VAL;
			star   = 1'b1;
		end else begin
			c1_key = 4'd0;
			c1_hit = 1'b0;
		end
	end

	always_comb begin
		c2_hit = 1'b1;
		if (!col2_rows[0]) begin
			c2_key = 4'd2;
		end else if (!col2_rows[3]) begin
			c2_key = 4'd5;
		end else if (!col2_rows[2]) begin
			c2_key = 4'd8;
		end else if (!col2_rows[1]) begin
			c2_key = 4'd0;
		end else begin
			c2_key = 4'd0;
			c2_hit = 1'b0;
		end
	end

	always_comb begin
		c3_hit = 1'b1;
		hash   = 1'b0;
		if (!col3_rows[0]) begin
			c3_key = 4'd3;
		end else if (!col3_rows[3]) begin
			c3_key = 4'd6;
		end else if (!col3_rows[2]) begin
			c3_key = 4'd9;
		end else begin
			c3_key = 4'd0;
			c3_hit = 1'b0;
			hash   = !col3_rows[1];
		end
	end

	// hash leaves the key alone, so column 2 still counts under it
	assign c23_hit = c2_hit | c3_hit;
	assign c23_key = c3_hit ? c3_key : c2_key;

	assign keys = {c1_hit, c1_key, star, c23_hit, c23_key, hash};

endmodule

`default_nettype wire

// ===== src/keypad_decimal_entry_duty_set.sv =====
// A result beat appears in the cycle after its beat is accepted.
// Throughput: one beat per cycle; the result register is refilled in the same
// cycle it is taken, so only a stalled result holds off new input.
// Every beat gives exactly one result. Reset (arst_n low, asynchronous)
// clears digits, key, position, duty and display phase, blanks the display
// (digit_enable all ones) and sets duty_limit to 1000.
// ----------------------------------------------------------------------------
// keypad_decimal_entry_duty_set
// Keypad decimal entry with duty commit and four-digit display multiplexing.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_decimal_entry_duty_set
	import kdds_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	kdds_in_if.sink                scan,
	kdds_out_if.source             result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [DUTY_W-1:0]  duty_limit_q;
	digit_t             digits_q [NUM_DIG];
	digit_t             last_key_q;
	logic [POS_W-1:0]   pos_q;
	logic               star_held_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [PHASE_W-1:0] phase_q;
	logic [SEG_W-1:0]   seg_q;
	logic [NUM_DIG-1:0] en_q;
	logic               out_valid_q;

	digit_t             digits_n [NUM_DIG];
	digit_t             last_key_n;
	logic [POS_W-1:0]   pos_n;
	logic               star_held_n;
	logic [DUTY_W-1:0]  duty_n;
	logic [PHASE_W-1:0] phase_n;
	logic [SEG_W-1:0]   seg_n;
	logic [NUM_DIG-1:0] en_n;
	logic [DUTY_W-1:0]  value;
	logic               accept;

	kdds_keys_t keys;

	// ---------------- configuration ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= DUTY_LIMIT_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr == ADDR_DUTY_LIMIT) begin
			duty_limit_q <= pwdata[DUTY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_DUTY_LIMIT) begin
			prdata = {{(APB_DW-DUTY_W){1'b0}}, duty_limit_q};
		end
	end

	// ---------------- handshake ----------------
	assign scan.ready = !out_valid_q || result.ready;
	assign accept     = scan.valid && scan.ready;

	kdds_key_decode u_decode (
		.col1_rows (scan.col1_rows),
		.col2_rows (scan.col2_rows),
		.col3_rows (scan.col3_rows),
		.keys      (keys)
	);

	// decimal value of the stored digits, index 3 is thousands
	assign value = DUTY_W'(digits_q[3]) * 14'd1000 + DUTY_W'(digits_q[2]) * 14'd100
		+ DUTY_W'(digits_q[1]) * 14'd10 + DUTY_W'(digits_q[0]);

	// ---------------- next state ----------------
	always_comb begin
		digits_n    = digits_q;
		last_key_n  = last_key_q;
		pos_n       = pos_q;
		star_held_n = star_held_q;
		duty_n      = duty_q;
		phase_n     = phase_q;
		seg_n       = seg_q;
		en_n        = en_q;

		if (scan.operation == OP_TICK) begin
			phase_n = phase_q + 1'b1;
			seg_n   = seg_of(digits_q[phase_n]);
			en_n    = ~(NUM_DIG'(1) << phase_n);
		end else begin
			if (keys.c1_hit) begin
				last_key_n = keys.c1_key;
			end
			// star counts once per press, on release
			if (keys.star) begin
				star_held_n = 1'b1;
			end else if (star_held_q) begin
				star_held_n = 1'b0;
				pos_n       = pos_q + 1'b1;
			end
			if (keys.c23_hit) begin
				last_key_n = keys.c23_key;
			end
			if (keys.hash) begin
				pos_n = '0;
				duty_n = '0;
				for (int i = 0; i < NUM_DIG; i++) begin
					digits_n[i] = '0;
				end
			end
			if (!pos_n[2]) begin
				digits_n[2'd3 - pos_n[1:0]] = last_key_n;
			end else begin
				// commit; hash forces position 0 so digits here are the stored ones
				pos_n = '0;
				if (value <= duty_limit_q) begin
					duty_n = value;
				end else begin
					duty_n = '0;
					for (int i = 0; i < NUM_DIG; i++) begin
						digits_n[i] = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIG; i++) begin
				digits_q[i] <= '0;
			end
			last_key_q  <= '0;
			pos_q       <= '0;
			star_held_q <= 1'b0;
			duty_q      <= '0;
			phase_q     <= '0;
			seg_q       <= '0;
			en_q        <= '1;
		end else if (accept) begin
			digits_q    <= digits_n;
			last_key_q  <= last_key_n;
			pos_q       <= pos_n;
			star_held_q <= star_held_n;
			duty_q      <= duty_n;
			phase_q     <= phase_n;
			seg_q       <= seg_n;
			en_q        <= en_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// state registers double as the result register
	assign result.valid        = out_valid_q;
	assign result.duty         = duty_q;
	assign result.segments     = seg_q;
	assign result.digit_enable = en_q;

	// ---------------- assertions ----------------
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !pos_q[2])
		else $error("entry position left at a commit value");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("accepted beat produced no result");

	a_tick_enable: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan.operation == OP_TICK |=> $onehot(~en_q))
		else $error("digit select not one-cold after tick");

	a_digits_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (digits_q[0] <= 4'd9 && digits_q[1] <= 4'd9
			&& digits_q[2] <= 4'd9 && digits_q[3] <= 4'd9))
		else $error("stored digit out of decimal range");

	a_no_accept_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !scan.ready)
		else $error("beat taken while result stalled");

endmodule

`default_nettype wire
